### hw/rtl/ris_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_pkg: shared types and codes of the rename/issue stage
// Payload structs, status, class and opcode codes, register indexes.
// ----------------------------------------------------------------------------
package ris_pkg;

  localparam int TAG_W  = 5;
  localparam int REG_W  = 6;
  localparam int CFG_W  = 4;
  localparam int CIDX_W = 3;
  localparam int NUM_CLASSES = 3;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_MULT = 2'd2,
    OP_DIV  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CLASS_ADDSUB = 2'd0,
    CLASS_MULT   = 2'd1,
    CLASS_DIV    = 2'd2
  } class_t;

  typedef enum logic [1:0] {
    STATUS_ISSUED       = 2'd0,
    STATUS_BUFFER_FULL  = 2'd1,
    STATUS_STATION_FULL = 2'd2,
    STATUS_BAD_REG      = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } stage_t;

  localparam logic [CIDX_W-1:0] CFG_ADDSUB_SLOTS = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_MULT_SLOTS   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_DIV_SLOTS    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_ADDSUB_UNITS = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_MULT_UNITS   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_DIV_UNITS    = 3'd5;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [REG_W-1:0] dest_reg;
    logic [REG_W-1:0] src_a_reg;
    logic [REG_W-1:0] src_b_reg;
  } issue_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TAG_W-1:0] rob_tag;
    logic [1:0]       station_class;
    logic [2:0]       station_slot;
    logic [2:0]       exec_unit;
    logic             src_a_waiting;
    logic [TAG_W-1:0] src_a_tag;
    logic             src_b_waiting;
    logic [TAG_W-1:0] src_b_tag;
  } result_item_t;

  function automatic logic [1:0] class_of(input logic [1:0] op);
    logic [1:0] c;
    case (op)
      OP_ADD, OP_SUB: c = CLASS_ADDSUB;
      OP_MULT:        c = CLASS_MULT;
      default:        c = CLASS_DIV;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/ris_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ris_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/rename_issue_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rename_issue_stage: register rename and issue stage of a reorder-buffer core
// Hands out buffer tags, station slots and round-robin execution units, and
// looks both sources up in the alias table before renaming the destination.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-----------------------------------
//  issue    | issue_valid / issue_ready  | issue_item  (opcode, dest, srcs)
//  result   | result_valid / result_ready| result_item (status, tag, ...)
//  config   | cfg_write                  | cfg_index, cfg_data
//
//  In each transaction the accepting edge reads both copies of the alias
//  table (one RAM per source, registered read data), and the lookup step
//  resolves the checks, updates the counters and renames the destination.
//  A finished result may wait while the next transaction is taken; the lookup
//  step stalls only while that result is still waiting. Reset clears the alias
//  table at once through per-entry valid bits, so there is no clearing pass.
//
module rename_issue_stage #(
  parameter int ROB_DEPTH = 16,
  parameter int ARCH_REGS = 32,
  parameter int MAX_SLOTS = 8,
  parameter int MAX_UNITS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        issue_valid,
  output logic                        issue_ready,
  input  ris_pkg::issue_item_t        issue_item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output ris_pkg::result_item_t       result_item,
  input  logic                        cfg_write,
  input  logic [ris_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [ris_pkg::CFG_W-1:0]   cfg_data
);

  import ris_pkg::*;

  localparam int AW     = $clog2(ARCH_REGS);
  localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
  localparam int UNIT_W = $clog2(MAX_UNITS + 1);

  // Control state.
  stage_t state, state_next;
  logic   finish;

  // Configuration registers, one per class.
  logic [CFG_W-1:0] slots_cfg [NUM_CLASSES];
  logic [2:0]       units_cfg [NUM_CLASSES];

  // Allocation state.
  logic [TAG_W-1:0]  rob_used;
  logic [SLOT_W-1:0] station_used [NUM_CLASSES];
  logic [UNIT_W-1:0] last_unit [NUM_CLASSES];
  logic [ARCH_REGS-1:0] alias_valid;

  // The instruction being resolved.
  issue_item_t item;

  // Alias table read ports.
  logic [AW-1:0]    raddr_a, raddr_b;
  logic [TAG_W-1:0] rdata_a, rdata_b;
  logic             alias_we;

  // Resolve step.
  logic [1:0]       cls;
  logic [1:0]       status;
  logic [CFG_W-1:0] slot_lim;
  logic [2:0]       unit_lim;
  logic [2:0]       unit;
  logic [TAG_W-1:0] tag, tag_a, tag_b;
  logic             in_range;
  result_item_t     result_next;

  assign issue_ready = (state == ST_IDLE);

  // While an instruction waits in the lookup step the read addresses come
  // from the held copy, so the read data stays valid across a stall.
  always_comb begin
    if (state == ST_IDLE) begin
      raddr_a = issue_item.src_a_reg[AW-1:0];
      raddr_b = issue_item.src_b_reg[AW-1:0];
    end else begin
      raddr_a = item.src_a_reg[AW-1:0];
      raddr_b = item.src_b_reg[AW-1:0];
    end
  end

  ris_ram #(.WIDTH(TAG_W), .DEPTH(ARCH_REGS)) u_alias_a (
    .clk   (clk),
    .we    (alias_we),
    .waddr (item.dest_reg[AW-1:0]),
    .wdata (tag),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  ris_ram #(.WIDTH(TAG_W), .DEPTH(ARCH_REGS)) u_alias_b (
    .clk   (clk),
    .we    (alias_we),
    .waddr (item.dest_reg[AW-1:0]),
    .wdata (tag),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Next state: an instruction is taken in idle and resolved in the lookup
  // step once the output register is free or is being emptied.
  always_comb begin
    state_next = state;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (issue_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!result_valid || result_ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Checks in priority order: buffer, station, register range. A slot limit
  // of zero leaves the class always full; the unit count is clamped to at
  // least one.
  always_comb begin
    cls = class_of(item.opcode);

    slot_lim = (slots_cfg[cls] > CFG_W'(MAX_SLOTS)) ? CFG_W'(MAX_SLOTS) : slots_cfg[cls];
    if (units_cfg[cls] == 3'd0) begin
      unit_lim = 3'd1;
    end else if (units_cfg[cls] > 3'(MAX_UNITS)) begin
      unit_lim = 3'(MAX_UNITS);
    end else begin
      unit_lim = units_cfg[cls];
    end

    in_range = (7'(item.dest_reg) < 7'(ARCH_REGS)) &&
               (7'(item.src_a_reg) < 7'(ARCH_REGS)) &&
               (7'(item.src_b_reg) < 7'(ARCH_REGS));

    if (rob_used >= TAG_W'(ROB_DEPTH)) begin
      status = STATUS_BUFFER_FULL;
    end else if (CFG_W'(station_used[cls]) >= slot_lim) begin
      status = STATUS_STATION_FULL;
    end else if (!in_range) begin
      status = STATUS_BAD_REG;
    end else begin
      status = STATUS_ISSUED;
    end

    tag = rob_used + TAG_W'(1);

    // Round robin wraps to the first unit when the last one given is at or
    // above the current count, which covers a count lowered after issues.
    if (last_unit[cls] == '0 || 3'(last_unit[cls]) >= unit_lim) begin
      unit = 3'd1;
    end else begin
      unit = 3'(last_unit[cls]) + 3'd1;
    end

    // Only meaningful for issued instructions, where both sources are in range.
    tag_a = alias_valid[item.src_a_reg[AW-1:0]] ? rdata_a : '0;
    tag_b = alias_valid[item.src_b_reg[AW-1:0]] ? rdata_b : '0;

    result_next = '0;
    result_next.status        = status;
    result_next.station_class = cls;
    if (status == STATUS_ISSUED) begin
      result_next.rob_tag       = tag;
      result_next.station_slot  = 3'(station_used[cls]);
      result_next.exec_unit     = unit;
      result_next.src_a_waiting = (tag_a != '0);
      result_next.src_a_tag     = tag_a;
      result_next.src_b_waiting = (tag_b != '0);
      result_next.src_b_tag     = tag_b;
    end

    alias_we = finish && (status == STATUS_ISSUED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      rob_used     <= '0;
      alias_valid  <= '0;
      slots_cfg[CLASS_ADDSUB] <= CFG_W'(3);
      slots_cfg[CLASS_MULT]   <= CFG_W'(2);
      slots_cfg[CLASS_DIV]    <= CFG_W'(2);
      units_cfg[CLASS_ADDSUB] <= 3'd2;
      units_cfg[CLASS_MULT]   <= 3'd1;
      units_cfg[CLASS_DIV]    <= 3'd1;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        station_used[i] <= '0;
        last_unit[i]    <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          CFG_ADDSUB_SLOTS: slots_cfg[CLASS_ADDSUB] <= cfg_data;
          CFG_MULT_SLOTS:   slots_cfg[CLASS_MULT]   <= cfg_data;
          CFG_DIV_SLOTS:    slots_cfg[CLASS_DIV]    <= cfg_data;
          CFG_ADDSUB_UNITS: units_cfg[CLASS_ADDSUB] <= cfg_data[2:0];
          CFG_MULT_UNITS:   units_cfg[CLASS_MULT]   <= cfg_data[2:0];
          CFG_DIV_UNITS:    units_cfg[CLASS_DIV]    <= cfg_data[2:0];
          default: ;
        endcase
      end

      if (finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (alias_we) begin
        rob_used                          <= tag;
        station_used[cls]                 <= station_used[cls] + SLOT_W'(1);
        last_unit[cls]                    <= UNIT_W'(unit);
        alias_valid[item.dest_reg[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (issue_valid && issue_ready) begin
      item <= issue_item;
    end
    if (finish) begin
      result_item <= result_next;
    end
  end

endmodule

### hw/rtl/ris_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_checker: port-level assertions for the rename/issue stage
// Watches the handshakes and the consistency of result fields.
// ----------------------------------------------------------------------------
module ris_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        issue_valid,
  input logic                        issue_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input ris_pkg::result_item_t       result_item
);

  import ris_pkg::*;

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_item))
    else $error("result changed while stalled");

  // Only one transaction is resolved at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    issue_valid && issue_ready |=> !issue_ready)
    else $error("issue accepted during lookup");

  // A rejected instruction carries no allocation.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.status != STATUS_ISSUED |->
      result_item.rob_tag == '0 && result_item.exec_unit == '0 &&
      result_item.station_slot == '0 && !result_item.src_a_waiting &&
      !result_item.src_b_waiting)
    else $error("rejected result carries allocation");

  // An issued instruction has a tag and a unit.
  a_issue_alloc: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.status == STATUS_ISSUED |->
      result_item.rob_tag != '0 && result_item.exec_unit != '0)
    else $error("issued result without tag or unit");

  // Waiting flags agree with their tags.
  a_wait_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      result_item.src_a_waiting == (result_item.src_a_tag != '0) &&
      result_item.src_b_waiting == (result_item.src_b_tag != '0))
    else $error("waiting flag disagrees with tag");

endmodule

bind rename_issue_stage ris_checker u_ris_checker (.*);

### dv/tb_rename_issue_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rename_issue_stage: self-checking testbench of the rename/issue stage
// A short directed table, then random instructions in several handshake phases.
// Every result is checked field by field against an in-bench model or a hand-typed one.
// ----------------------------------------------------------------------------
module tb_rename_issue_stage;

  import ris_pkg::*;

  // Geometry of the instance. The model below uses the same numbers.
  localparam int ROB_DEPTH = 16;
  localparam int ARCH_REGS = 32;
  localparam int MAX_SLOTS = 8;
  localparam int MAX_UNITS = 4;
  localparam int AW        = $clog2(ARCH_REGS);

  // Register indexes past the last real register. Writes to them must be
  // ignored by the block.
  localparam logic [CIDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam int RANDOM_PHASES   = 5;
  localparam int ITEMS_PER_PHASE = 220;
  // Length of the long receiver hold-off in the pressure phase, in cycles.
  localparam int CHOKE_CYCLES    = 200;

  // One row of the directed table: either an instruction or a register write.
  // A pinned row carries its expected result typed in by hand.
  typedef struct {
    bit                  is_reg_write;
    issue_item_t         instr;
    bit                  pinned;
    result_item_t        want;
    logic [CIDX_W-1:0]   reg_index;
    logic [CFG_W-1:0]    reg_value;
  } stim_row_t;

  logic         clk;
  logic         rst;
  logic         issue_valid;
  logic         issue_ready;
  issue_item_t  issue_item;
  logic         result_valid;
  logic         result_ready;
  result_item_t result_item;
  logic         cfg_write;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  // Hand-typed expectation that travels with the instruction on offer.
  logic         pin_active;
  result_item_t pin_result;

  // Handshake shaping, set by the main sequence per phase.
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned choke_req;
  int unsigned choke_done;

  // Model state: configuration and the rename/issue bookkeeping.
  int unsigned slot_cfg[NUM_CLASSES];
  int unsigned unit_cfg[NUM_CLASSES];
  int unsigned tags_issued;
  int unsigned slots_taken[NUM_CLASSES];
  int unsigned prev_unit[NUM_CLASSES];
  logic [TAG_W-1:0] pending_tag[ARCH_REGS];

  result_item_t expected_results[$];
  stim_row_t    directed_rows[$];

  int unsigned errors;
  int unsigned instrs_accepted;
  int unsigned status_seen[4];

  rename_issue_stage #(
    .ROB_DEPTH (ROB_DEPTH),
    .ARCH_REGS (ARCH_REGS),
    .MAX_SLOTS (MAX_SLOTS),
    .MAX_UNITS (MAX_UNITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .issue_valid  (issue_valid),
    .issue_ready  (issue_ready),
    .issue_item   (issue_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Safety net: the slowest legal run finishes far earlier than this.
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model of the stage
  // --------------------------------------------------------------------------

  // Back to the power-up state: default register values, nothing handed out.
  function automatic void clear_model();
    slot_cfg[CLASS_ADDSUB] = 3;
    slot_cfg[CLASS_MULT]   = 2;
    slot_cfg[CLASS_DIV]    = 2;
    unit_cfg[CLASS_ADDSUB] = 2;
    unit_cfg[CLASS_MULT]   = 1;
    unit_cfg[CLASS_DIV]    = 1;
    tags_issued = 0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      slots_taken[c] = 0;
      prev_unit[c]   = 0;
    end
    for (int r = 0; r < ARCH_REGS; r++) pending_tag[r] = '0;
  endfunction

  // Mirrors a register write. Unit counts keep only their low three bits, and
  // indexes past the last register leave everything as it was.
  function automatic void model_reg_write(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_ADDSUB_SLOTS: slot_cfg[CLASS_ADDSUB] = 32'(val);
      CFG_MULT_SLOTS:   slot_cfg[CLASS_MULT]   = 32'(val);
      CFG_DIV_SLOTS:    slot_cfg[CLASS_DIV]    = 32'(val);
      CFG_ADDSUB_UNITS: unit_cfg[CLASS_ADDSUB] = 32'(val[2:0]);
      CFG_MULT_UNITS:   unit_cfg[CLASS_MULT]   = 32'(val[2:0]);
      CFG_DIV_UNITS:    unit_cfg[CLASS_DIV]    = 32'(val[2:0]);
      default: ;
    endcase
  endfunction

  // Works out the result of one accepted instruction and advances the model.
  // Checks run in a fixed order: buffer, then station, then register range.
  // A rejected instruction still reports its class but changes no state.
  function automatic result_item_t rename_and_issue(issue_item_t it);
    result_item_t r;
    class_t       cls;
    int unsigned  cap;
    int unsigned  units;
    int unsigned  tag;
    int unsigned  unit;
    logic [TAG_W-1:0] ta;
    logic [TAG_W-1:0] tb;
    r = '0;
    case (opcode_t'(it.opcode))
      OP_ADD, OP_SUB: cls = CLASS_ADDSUB;
      OP_MULT:        cls = CLASS_MULT;
      default:        cls = CLASS_DIV;
    endcase
    r.station_class = cls;
    // Slot count above the station size is clamped; zero means always full.
    cap = (slot_cfg[cls] > MAX_SLOTS) ? MAX_SLOTS : slot_cfg[cls];
    units = unit_cfg[cls];
    if (units < 1) units = 1;
    if (units > MAX_UNITS) units = MAX_UNITS;
    if (tags_issued >= ROB_DEPTH) begin
      r.status = STATUS_BUFFER_FULL;
    end else if (slots_taken[cls] >= cap) begin
      r.status = STATUS_STATION_FULL;
    end else if (it.dest_reg >= ARCH_REGS || it.src_a_reg >= ARCH_REGS ||
                 it.src_b_reg >= ARCH_REGS) begin
      r.status = STATUS_BAD_REG;
    end else begin
      r.status = STATUS_ISSUED;
      tag = tags_issued + 1;
      tags_issued = tag;
      r.station_slot = 3'(slots_taken[cls]);
      slots_taken[cls]++;
      // Round robin restarts at unit 1, also when the count shrank meanwhile.
      if (prev_unit[cls] == 0 || prev_unit[cls] >= units) unit = 1;
      else unit = prev_unit[cls] + 1;
      prev_unit[cls] = unit;
      // Sources see the table before the destination is renamed, so an
      // instruction that reads its own destination waits on the older tag.
      ta = pending_tag[it.src_a_reg[AW-1:0]];
      tb = pending_tag[it.src_b_reg[AW-1:0]];
      pending_tag[it.dest_reg[AW-1:0]] = TAG_W'(tag);
      r.rob_tag       = TAG_W'(tag);
      r.exec_unit     = 3'(unit);
      r.src_a_waiting = (ta != '0);
      r.src_a_tag     = ta;
      r.src_b_waiting = (tb != '0);
      r.src_b_tag     = tb;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table helpers
  // --------------------------------------------------------------------------

  function automatic issue_item_t make_instr(opcode_t op, int d, int a, int b);
    issue_item_t it;
    it.opcode    = op;
    it.dest_reg  = REG_W'(d);
    it.src_a_reg = REG_W'(a);
    it.src_b_reg = REG_W'(b);
    return it;
  endfunction

  // A hand-typed result with no source waiting.
  function automatic result_item_t verdict(status_t s, class_t c, int tag, int slot,
                                           int unit);
    result_item_t r;
    r = '0;
    r.status        = s;
    r.station_class = c;
    r.rob_tag       = TAG_W'(tag);
    r.station_slot  = 3'(slot);
    r.exec_unit     = 3'(unit);
    return r;
  endfunction

  function automatic void add_instr(opcode_t op, int d, int a, int b);
    stim_row_t row;
    row = '{default: '0};
    row.instr = make_instr(op, d, a, b);
    directed_rows.push_back(row);
  endfunction

  function automatic void add_pinned(opcode_t op, int d, int a, int b, result_item_t want);
    stim_row_t row;
    row = '{default: '0};
    row.instr  = make_instr(op, d, a, b);
    row.pinned = 1'b1;
    row.want   = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg_write(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_reg_write = 1'b1;
    row.reg_index    = idx;
    row.reg_value    = val;
    directed_rows.push_back(row);
  endfunction

  // Mostly low registers so that renames chain; some out of range.
  function automatic logic [REG_W-1:0] random_reg();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return REG_W'($urandom_range(63, 32));
    if (pick < 55) return REG_W'($urandom_range(7));
    return REG_W'($urandom_range(31));
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Offers one instruction and returns at the rising edge that accepts it.
  // Entered right after an accepting edge, so the first negedge may either
  // switch to the next payload or start an idle gap.
  task automatic offer_instr(issue_item_t it, bit pinned, result_item_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      issue_valid <= 1'b0;
      @(negedge clk);
    end
    issue_valid <= 1'b1;
    issue_item  <= it;
    pin_active  <= pinned;
    pin_result  <= want;
    do @(posedge clk); while (!issue_ready);
  endtask

  // Lets the block run dry: no instruction offered and no result outstanding,
  // then a short pause for any work still inside the two-stage pipeline.
  task automatic drain();
    @(negedge clk);
    issue_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    model_reg_write(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Receiver side. Normally a random stall per cycle; on request it holds
  // ready low for a long, counted stretch so the pipeline backs up.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (choke_req != choke_done) begin
        result_ready <= 1'b0;
        for (int n = 1; n < CHOKE_CYCLES; n++) @(negedge clk);
        choke_done = choke_req;
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Sampled at the rising edge, before the block's own updates land. The
  // result is checked before the new instruction is predicted; a result can
  // never belong to an instruction accepted at the same edge.
  always @(posedge clk) begin
    result_item_t want;
    result_item_t predicted;
    if (!rst) begin
      if (result_valid && result_ready) begin
        status_seen[result_item.status]++;
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, expected none, actual %p",
                   $time, result_item);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status",        want.status,        result_item.status);
          check_field("rob_tag",       want.rob_tag,       result_item.rob_tag);
          check_field("station_class", want.station_class, result_item.station_class);
          check_field("station_slot",  want.station_slot,  result_item.station_slot);
          check_field("exec_unit",     want.exec_unit,     result_item.exec_unit);
          check_field("src_a_waiting", want.src_a_waiting, result_item.src_a_waiting);
          check_field("src_a_tag",     want.src_a_tag,     result_item.src_a_tag);
          check_field("src_b_waiting", want.src_b_waiting, result_item.src_b_waiting);
          check_field("src_b_tag",     want.src_b_tag,     result_item.src_b_tag);
        end
      end
      if (issue_valid && issue_ready) begin
        // The model always advances; a pinned row replaces only the result.
        predicted = rename_and_issue(issue_item);
        expected_results.push_back(pin_active ? pin_result : predicted);
        instrs_accepted++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    logic [CIDX_W-1:0] real_regs[6];
    stim_row_t row;
    issue_item_t it;

    rst           = 1'b1;
    issue_valid   = 1'b0;
    issue_item    = '0;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    pin_active    = 1'b0;
    pin_result    = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    choke_req     = 0;
    choke_done    = 0;
    errors        = 0;
    instrs_accepted = 0;
    for (int s = 0; s < 4; s++) status_seen[s] = 0;
    real_regs = '{CFG_ADDSUB_SLOTS, CFG_MULT_SLOTS, CFG_DIV_SLOTS,
                  CFG_ADDSUB_UNITS, CFG_MULT_UNITS, CFG_DIV_UNITS};
    clear_model();

    // Directed table. Buffer tags are never freed and reset comes only once,
    // so the table spends twelve of the sixteen tags and leaves the rest,
    // and the buffer-full regime, to the random part.
    // Out-of-range registers in each position, on a fresh block.
    add_pinned(OP_ADD,  32, 0, 0,  verdict(STATUS_BAD_REG, CLASS_ADDSUB, 0, 0, 0));
    add_pinned(OP_MULT, 0, 63, 0,  verdict(STATUS_BAD_REG, CLASS_MULT, 0, 0, 0));
    add_pinned(OP_DIV,  0, 0, 63,  verdict(STATUS_BAD_REG, CLASS_DIV, 0, 0, 0));
    // First issue after reset: tag 1, slot 0, unit 1, nothing pending.
    add_pinned(OP_ADD,  0, 0, 0,   verdict(STATUS_ISSUED, CLASS_ADDSUB, 1, 0, 1));
    // Dependencies, including a source equal to the destination.
    add_instr(OP_SUB,  31, 0, 31);
    add_instr(OP_ADD,  0, 31, 0);
    // Station full takes precedence over a bad register.
    add_pinned(OP_SUB, 63, 63, 63, verdict(STATUS_STATION_FULL, CLASS_ADDSUB, 0, 0, 0));
    add_instr(OP_MULT, 5, 0, 31);
    add_instr(OP_MULT, 5, 5, 5);
    add_instr(OP_MULT, 1, 1, 1);
    add_instr(OP_DIV,  6, 5, 0);
    add_instr(OP_DIV,  31, 6, 6);
    add_pinned(OP_DIV, 40, 2, 2,   verdict(STATUS_STATION_FULL, CLASS_DIV, 0, 0, 0));
    // A slot count of zero makes the class permanently full.
    add_reg_write(CFG_ADDSUB_SLOTS, 4'd0);
    add_pinned(OP_ADD, 1, 2, 3,    verdict(STATUS_STATION_FULL, CLASS_ADDSUB, 0, 0, 0));
    // Clamping at the top: 15 slots act as the station size, a unit count
    // of 15 keeps 7 and then acts as the unit maximum. Zero units acts as one.
    // The two unused indexes are written and must change nothing.
    add_reg_write(CFG_ADDSUB_SLOTS, 4'd15);
    add_reg_write(CFG_ADDSUB_UNITS, 4'd15);
    add_reg_write(CFG_MULT_SLOTS,   4'd8);
    add_reg_write(CFG_MULT_UNITS,   4'd0);
    add_reg_write(CFG_SPARE_A,      4'd0);
    add_reg_write(CFG_SPARE_B,      4'd15);
    add_instr(OP_ADD, 2, 0, 31);
    add_instr(OP_SUB, 3, 2, 6);
    add_instr(OP_ADD, 31, 31, 3);
    // Unit count lowered below the last unit handed out: wraps to unit 1.
    add_reg_write(CFG_ADDSUB_UNITS, 4'd2);
    add_instr(OP_SUB,  4, 4, 31);
    add_instr(OP_MULT, 7, 5, 7);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_reg_write) write_reg(row.reg_index, row.reg_value);
      else offer_instr(row.instr, row.pinned, row.want);
    end

    // Random part. Each phase starts from a fresh random configuration over
    // the full field range, then runs with its own idle and stall mix. The
    // last phase holds the receiver off long enough to stall the input side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      foreach (real_regs[k]) write_reg(real_regs[k], CFG_W'($urandom_range(15)));
      if (ph == 2) write_reg(CFG_SPARE_A, CFG_W'($urandom_range(15)));
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        3: begin send_idle_pct = 38; stall_pct = 38; end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
          choke_req++;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.opcode    = 2'($urandom_range(3));
        it.dest_reg  = random_reg();
        it.src_a_reg = random_reg();
        it.src_b_reg = random_reg();
        offer_instr(it, 1'b0, '0);
      end
    end

    drain();
    send_idle_pct = 0;
    stall_pct     = 0;
    // Anything the block still emits now has no expectation and is caught.
    repeat (10) @(posedge clk);

    $display("Run covered %0d instructions: %0d issued, %0d buffer full, %0d station full,",
             instrs_accepted, status_seen[STATUS_ISSUED], status_seen[STATUS_BUFFER_FULL],
             status_seen[STATUS_STATION_FULL]);
    $display("%0d bad register, over %0d random configurations and a long output stall.",
             status_seen[STATUS_BAD_REG], RANDOM_PHASES);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
